/* src/dit_pkg.sv */
// Shared types and constants for the dual interval timer and port chip.
// No dependencies; imported by dit_timer and the top level.
`default_nettype none

package dit_pkg;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [3:0] REG_PORT_A  = 4'd0;
	localparam logic [3:0] REG_PORT_B  = 4'd1;
	localparam logic [3:0] REG_TA_LO   = 4'd4;
	localparam logic [3:0] REG_TA_HI   = 4'd5;
	localparam logic [3:0] REG_TB_LO   = 4'd6;
	localparam logic [3:0] REG_TB_HI   = 4'd7;
	localparam logic [3:0] REG_ICR     = 4'd13;
	localparam logic [3:0] REG_CRA     = 4'd14;
	localparam logic [3:0] REG_CRB     = 4'd15;

	localparam logic [7:0] PORT_RESET  = 8'hff;

	// Control bits of the timer control registers
	localparam int CR_START_BIT = 0;
	localparam int CR_LOAD_BIT  = 4;
	localparam int CR_SRC_LSB   = 5;
	localparam int ICR_SET_BIT  = 7;

	// Commands from the register decode to a timer for the item in the input stage
	typedef struct packed {
		logic        wr_lo;     // write low latch byte
		logic        wr_hi;     // write high latch byte
		logic        load;      // force latch into counter
		logic        ie_wr;     // update interrupt enable
		logic        ie_val;
		logic [7:0]  data;
		logic        tick;      // counting tick for this timer
		logic [31:0] elapsed;
	} tmr_ctl_t;

endpackage

`default_nettype wire

/* src/dit_timer.sv */
// One 16-bit down-counting interval timer with latch, interrupt enable and sticky flag.
// Depends on dit_pkg (tmr_ctl_t).
`default_nettype none

module dit_timer
	import dit_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,      // stage advances this cycle
	input  wire tmr_ctl_t    ctl,
	output logic [15:0]      count,
	output logic             flag,
	output logic             nmi
);

	logic [15:0] latch_q;
	logic [15:0] count_q;
	logic        ie_q;
	logic        flag_q;
	logic        reached;
	logic        fire;

	// count <= elapsed, without a full 32-bit compare
	assign reached = (ctl.elapsed[31:16] != 16'd0) || (count_q <= ctl.elapsed[15:0]);
	assign fire    = ctl.tick && reached;
	assign nmi     = fire && ie_q;
	assign count   = count_q;
	assign flag    = flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 16'd0;
			count_q <= 16'd0;
			ie_q    <= 1'b0;
			flag_q  <= 1'b0;
		end else if (en) begin
			if (ctl.wr_lo) begin
				latch_q[7:0] <= ctl.data;
			end
			if (ctl.wr_hi) begin
				latch_q[15:8] <= ctl.data;
			end
			if (ctl.ie_wr) begin
				ie_q <= ctl.ie_val;
			end
			if (ctl.load) begin
				count_q <= latch_q;
			end else if (fire) begin
				count_q <= latch_q;
			end else if (ctl.tick) begin
				count_q <= count_q - ctl.elapsed[15:0];
			end
			if (nmi) begin
				flag_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/dual_interval_timer_port_chip_top.sv */
// Top level of the dual interval timer and port chip: input stage, register decode,
// read mux and result register. Depends on dit_pkg and dit_timer.
`default_nettype none

// Each input transfer is a register write, a register read, a tick or a no-op. The
// block takes one transfer per clock while in_stall is low: an item is captured in
// the input stage, and when the stage advances all register and timer state is
// updated and the result (read_data, nmi_pulses) lands in the result register.
// The rate is set by the state update of the timer stage (one 32-bit elapsed
// subtract, then a compare and a 16-bit subtract per timer). The result register
// parts the two sides: a new item is taken while a finished result waits, and
// in_stall rises only when the stage is full and its result cannot move out.
// Every item yields exactly one result; writes and ticks read back zero, reads and
// writes report zero NMI pulses. Interrupt flags are sticky until reset.
module dual_interval_timer_port_chip_top
	import dit_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [3:0]  reg_index,
	input  wire logic [7:0]  write_data,
	input  wire logic [31:0] cycle_count,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       read_data,
	output logic [1:0]       nmi_pulses
);

	// Input stage
	logic        valid_s1;
	op_t         op_s1;
	logic [3:0]  reg_s1;
	logic [7:0]  wdata_s1;
	logic [31:0] cyc_s1;

	// Architectural state outside the timers
	logic [7:0]  port_a_q;
	logic [7:0]  port_b_q;
	logic        run_a_q;
	logic        run_b_q;
	logic        src_a_q;
	logic [1:0]  src_b_q;
	logic [31:0] last_cyc_q;

	// Result register
	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic [1:0]  nmi_q;

	logic        adv;
	logic        in_xfer;
	logic        is_wr;
	logic        is_rd;
	logic        is_tick;
	logic [31:0] elapsed;
	tmr_ctl_t    ctl_a;
	tmr_ctl_t    ctl_b;
	logic [15:0] count_a;
	logic [15:0] count_b;
	logic        flag_a;
	logic        flag_b;
	logic        nmi_a;
	logic        nmi_b;
	logic [7:0]  rd_mux;

	// Stage moves when the result register is empty or draining this cycle
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1    <= op_t'(operation);
			reg_s1   <= reg_index;
			wdata_s1 <= write_data;
			cyc_s1   <= cycle_count;
		end
	end

	assign is_wr   = (op_s1 == OP_WRITE);
	assign is_rd   = (op_s1 == OP_READ);
	assign is_tick = (op_s1 == OP_TICK);
	assign elapsed = cyc_s1 - last_cyc_q;

	// Timer commands; only processor-clock sources count
	always_comb begin
		ctl_a         = '0;
		ctl_a.data    = wdata_s1;
		ctl_a.elapsed = elapsed;
		ctl_a.wr_lo   = is_wr && (reg_s1 == REG_TA_LO);
		ctl_a.wr_hi   = is_wr && (reg_s1 == REG_TA_HI);
		ctl_a.load    = is_wr && (reg_s1 == REG_CRA) && wdata_s1[CR_LOAD_BIT];
		ctl_a.ie_wr   = is_wr && (reg_s1 == REG_ICR) && wdata_s1[0];
		ctl_a.ie_val  = wdata_s1[ICR_SET_BIT];
		ctl_a.tick    = is_tick && run_a_q && !src_a_q;

		ctl_b         = '0;
		ctl_b.data    = wdata_s1;
		ctl_b.elapsed = elapsed;
		ctl_b.wr_lo   = is_wr && (reg_s1 == REG_TB_LO);
		ctl_b.wr_hi   = is_wr && (reg_s1 == REG_TB_HI);
		ctl_b.load    = is_wr && (reg_s1 == REG_CRB) && wdata_s1[CR_LOAD_BIT];
		ctl_b.ie_wr   = is_wr && (reg_s1 == REG_ICR) && wdata_s1[1];
		ctl_b.ie_val  = wdata_s1[ICR_SET_BIT];
		ctl_b.tick    = is_tick && run_b_q && (src_b_q == 2'd0);
	end

	dit_timer u_timer_a (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.ctl    (ctl_a),
		.count  (count_a),
		.flag   (flag_a),
		.nmi    (nmi_a)
	);

	dit_timer u_timer_b (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.ctl    (ctl_b),
		.count  (count_b),
		.flag   (flag_b),
		.nmi    (nmi_b)
	);

	// Ports, control bits and tick reference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_a_q   <= PORT_RESET;
			port_b_q   <= PORT_RESET;
			run_a_q    <= 1'b0;
			run_b_q    <= 1'b0;
			src_a_q    <= 1'b0;
			src_b_q    <= 2'd0;
			last_cyc_q <= 32'd0;
		end else if (adv) begin
			if (is_wr) begin
				case (reg_s1)
					REG_PORT_A: begin
						port_a_q <= wdata_s1;
					end
					REG_PORT_B: begin
						port_b_q <= wdata_s1;
					end
					REG_CRA: begin
						run_a_q <= wdata_s1[CR_START_BIT];
						src_a_q <= wdata_s1[CR_SRC_LSB];
					end
					REG_CRB: begin
						run_b_q <= wdata_s1[CR_START_BIT];
						src_b_q <= wdata_s1[CR_SRC_LSB +: 2];
					end
					default: begin
					end
				endcase
			end
			if (is_tick) begin
				last_cyc_q <= cyc_s1;
			end
		end
	end

	// Read mux; inert registers read zero
	always_comb begin
		rd_mux = 8'd0;
		if (is_rd) begin
			case (reg_s1)
				REG_PORT_A: rd_mux = port_a_q;
				REG_PORT_B: rd_mux = port_b_q;
				REG_TA_LO:  rd_mux = count_a[7:0];
				REG_TA_HI:  rd_mux = count_a[15:8];
				REG_TB_LO:  rd_mux = count_b[7:0];
				REG_TB_HI:  rd_mux = count_b[15:8];
				REG_ICR:    rd_mux = {(flag_a || flag_b), 5'd0, flag_b, flag_a};
				default:    rd_mux = 8'd0;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q <= rd_mux;
			nmi_q       <= {1'b0, nmi_a} + {1'b0, nmi_b};
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign nmi_pulses = nmi_q;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for dual_interval_timer_port_chip_top: bus writes, reads and ticks
// are checked against an in-bench model of the ports, timers and interrupt flags.
// Depends on dit_pkg and the RTL of the block; reads no files.

module tb_top;
	import dit_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 10;   // margin after the last result
	localparam int RANDOM_ITEMS = 600;

	// one bus transfer as the sender sees it, with the idle cycles placed before it
	typedef struct {
		op_t         op;
		logic [3:0]  idx;
		logic [7:0]  data;
		logic [31:0] cyc;
		int          gap;
		bit          drain;   // hold this transfer until every result is back
	} bus_item_t;

	typedef struct {
		logic [7:0] rd;
		logic [1:0] nmi;
	} chip_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	op_t         operation = OP_NONE;
	logic [3:0]  reg_index = '0;
	logic [7:0]  write_data = '0;
	logic [31:0] cycle_count = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  read_data;
	logic [1:0]  nmi_pulses;

	dual_interval_timer_port_chip_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.reg_index(reg_index),
		.write_data(write_data),
		.cycle_count(cycle_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.nmi_pulses(nmi_pulses)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Chip model: port bytes, two timers, interrupt enables and flags
	// ---------------------------------------------------------------
	logic [7:0]  port_a_q, port_b_q;
	logic [15:0] tmr_latch [2];
	logic [15:0] tmr_count [2];
	bit          tmr_run [2];
	bit          tmr_ie [2];
	bit          tmr_flag [2];
	logic        src_a;
	logic [1:0]  src_b;
	logic [31:0] last_cyc;

	// Pending transfers, expected results and bookkeeping
	bus_item_t    pend_q [$];
	chip_result_t result_q [$];
	int           errors = 0;
	int           results_seen = 0;
	int           cycles = 0;
	int           gen_n = 0;
	logic [31:0]  gen_cyc = '0;

	// Count one timer down by the elapsed cycles; a hit reloads from the latch
	// and, only with its interrupt enabled, sets the sticky flag.
	function automatic int count_down(int t, logic [31:0] elapsed);
		int hit;
		hit = 0;
		if ({16'b0, tmr_count[t]} <= elapsed) begin
			if (tmr_ie[t]) begin
				tmr_flag[t] = 1'b1;
				hit = 1;
			end
			tmr_count[t] = tmr_latch[t];
		end else begin
			tmr_count[t] = tmr_count[t] - elapsed[15:0];
		end
		return hit;
	endfunction

	task automatic chip_predict(input bus_item_t it, output chip_result_t res);
		logic [31:0] elapsed;
		int nmi;
		nmi = 0;
		res.rd = '0;
		case (it.op)
			OP_WRITE: begin
				case (it.idx)
					REG_PORT_A: port_a_q = it.data;
					REG_PORT_B: port_b_q = it.data;
					REG_TA_LO: tmr_latch[0][7:0] = it.data;
					REG_TA_HI: tmr_latch[0][15:8] = it.data;
					REG_TB_LO: tmr_latch[1][7:0] = it.data;
					REG_TB_HI: tmr_latch[1][15:8] = it.data;
					REG_ICR: begin
						if (it.data[0]) tmr_ie[0] = it.data[ICR_SET_BIT];
						if (it.data[1]) tmr_ie[1] = it.data[ICR_SET_BIT];
					end
					REG_CRA: begin
						tmr_run[0] = it.data[CR_START_BIT];
						src_a = it.data[CR_SRC_LSB];
						if (it.data[CR_LOAD_BIT]) tmr_count[0] = tmr_latch[0];
					end
					REG_CRB: begin
						tmr_run[1] = it.data[CR_START_BIT];
						src_b = it.data[CR_SRC_LSB +: 2];
						if (it.data[CR_LOAD_BIT]) tmr_count[1] = tmr_latch[1];
					end
					default: ;
				endcase
			end
			OP_READ: begin
				case (it.idx)
					REG_PORT_A: res.rd = port_a_q;
					REG_PORT_B: res.rd = port_b_q;
					REG_TA_LO: res.rd = tmr_count[0][7:0];
					REG_TA_HI: res.rd = tmr_count[0][15:8];
					REG_TB_LO: res.rd = tmr_count[1][7:0];
					REG_TB_HI: res.rd = tmr_count[1][15:8];
					REG_ICR: begin
						if (tmr_flag[0] || tmr_flag[1])
							res.rd = {1'b1, 5'b0, tmr_flag[1], tmr_flag[0]};
					end
					default: ;
				endcase
			end
			OP_TICK: begin
				elapsed = it.cyc - last_cyc;   // wraps modulo 2^32
				if (tmr_run[0] && src_a == 1'b0) nmi += count_down(0, elapsed);
				if (tmr_run[1] && src_b == 2'd0) nmi += count_down(1, elapsed);
				last_cyc = it.cyc;
			end
			default: ;
		endcase
		res.nmi = nmi[1:0];
	endtask

	// Idle lengths: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Queue one transfer. Every fourth block of 64 transfers goes back to back.
	task automatic add_item(input op_t op, input logic [3:0] idx, input logic [7:0] d,
			input logic [31:0] c, input bit drain);
		bus_item_t it;
		it.op = op;
		it.idx = idx;
		it.data = d;
		it.cyc = c;
		it.gap = ((gen_n / 64) % 4 == 1) ? 0 : pick_gap();
		it.drain = drain;
		pend_q.push_back(it);
		gen_n++;
	endtask

	task automatic add_write(input logic [3:0] idx, input logic [7:0] d);
		add_item(OP_WRITE, idx, d, $urandom, 1'b0);
	endtask

	task automatic add_read(input logic [3:0] idx);
		add_item(OP_READ, idx, 8'($urandom), $urandom, 1'b0);
	endtask

	task automatic add_tick(input logic [31:0] c);
		add_item(OP_TICK, 4'($urandom), 8'($urandom), c, 1'b0);
	endtask

	// ---------------------------------------------------------------
	// Driver: offers pending transfers, runs the model on each accepted one
	// ---------------------------------------------------------------
	bus_item_t    drv_item;
	bus_item_t    drv_head;
	chip_result_t drv_res;
	int           drv_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			drv_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				chip_predict(drv_item, drv_res);
				result_q.push_back(drv_res);
			end
			// a stalled transfer stays put; otherwise the slot is free
			if (!(in_valid && in_stall)) begin
				if (drv_gap > 0) begin
					drv_gap--;
					in_valid <= 1'b0;
				end else if (pend_q.size() > 0 &&
						(!pend_q[0].drain || result_q.size() == 0)) begin
					if (pend_q[0].gap > 0) begin
						drv_gap = pend_q[0].gap - 1;
						drv_head = pend_q[0];
						drv_head.gap = 0;
						pend_q[0] = drv_head;
						in_valid <= 1'b0;
					end else begin
						drv_item = pend_q.pop_front();
						in_valid <= 1'b1;
						operation <= drv_item.op;
						reg_index <= drv_item.idx;
						write_data <= drv_item.data;
						cycle_count <= drv_item.cyc;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: random stalls, one long hold-off that backs up the block,
	// and a stall-free window every fourth block of 64 results
	// ---------------------------------------------------------------
	int stall_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (!hold_done && results_seen >= 200) begin
			hold_done = 1'b1;
			stall_left = 79;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ((results_seen / 64) % 4 == 3 || $urandom_range(0, 99) < 70) begin
			out_stall <= 1'b0;
		end else begin
			stall_left = pick_gap();
			out_stall <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: each result transfer against the oldest expectation
	// ---------------------------------------------------------------
	chip_result_t mon_exp;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (result_q.size() == 0) begin
				$display("%0t: result with nothing expected, read_data %02h nmi_pulses %0d",
					$time, read_data, nmi_pulses);
				errors++;
			end else begin
				mon_exp = result_q.pop_front();
				if (read_data !== mon_exp.rd) begin
					$display("%0t: read_data expected %02h actual %02h",
						$time, mon_exp.rd, read_data);
					errors++;
				end
				if (nmi_pulses !== mon_exp.nmi) begin
					$display("%0t: nmi_pulses expected %0d actual %0d",
						$time, mon_exp.nmi, nmi_pulses);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------
	int r, s;
	logic [3:0] ridx;
	logic [7:0] rdat;

	initial begin
		// model state after reset
		port_a_q = PORT_RESET;
		port_b_q = PORT_RESET;
		for (int t = 0; t < 2; t++) begin
			tmr_latch[t] = '0;
			tmr_count[t] = '0;
			tmr_run[t] = 1'b0;
			tmr_ie[t] = 1'b0;
			tmr_flag[t] = 1'b0;
		end
		src_a = 1'b0;
		src_b = 2'd0;
		last_cyc = '0;

		// directed: ports at reset and at both extremes, an inert register
		add_read(REG_PORT_A);
		add_read(REG_PORT_B);
		add_write(REG_PORT_A, 8'h00);
		add_read(REG_PORT_A);
		add_write(REG_PORT_B, 8'h00);
		add_read(REG_PORT_B);
		add_write(4'd2, 8'hff);
		add_read(4'd2);
		add_read(REG_ICR);
		// timer A at count 0 fires even with zero cycles elapsed
		add_write(REG_ICR, 8'h81);
		add_write(REG_CRA, 8'h01);
		add_tick(32'd0);
		add_read(REG_ICR);
		// load 3, count down by 1 then by 2 to fire; flag stays set across reads
		add_write(REG_TA_LO, 8'h03);
		add_write(REG_TA_HI, 8'h00);
		add_write(REG_CRA, 8'h11);
		add_tick(32'd1);
		add_read(REG_TA_LO);
		add_tick(32'd3);
		add_read(REG_ICR);
		// timer B on a non-processor source does not count
		add_write(REG_TB_LO, 8'hff);
		add_write(REG_TB_HI, 8'hff);
		add_write(REG_CRB, 8'h71);
		add_tick(32'hffff_ffff);
		add_read(REG_TB_HI);
		// B back on the processor clock, interrupt off: it reloads, no flag, no pulse
		add_write(REG_ICR, 8'h02);
		add_write(REG_CRB, 8'h11);
		add_tick(32'h0000_fffe);
		add_read(REG_ICR);
		add_item(OP_NONE, 4'($urandom), 8'($urandom), $urandom, 1'b0);
		add_read(REG_CRA);
		gen_cyc = 32'h0000_fffe;

		// random: ticks most often, with small steps so timers fire often, plus register
		// traffic that keeps latches small, timers running and interrupts enabled
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			s = $urandom_range(0, 99);
			if (r < 45) begin
				if (s < 70) gen_cyc += $urandom_range(0, 40);
				else if (s < 90) gen_cyc += $urandom_range(0, 600);
				else if (s < 97) gen_cyc += $urandom_range(0, 70000);
				else gen_cyc = $urandom;
				add_item(OP_TICK, 4'($urandom), 8'($urandom), gen_cyc, (i % 150) == 149);
			end else if (r < 70) begin
				if (s < 20) ridx = REG_ICR;
				else if (s < 50) ridx = 4'($urandom_range(REG_TA_LO, REG_TB_HI));
				else ridx = 4'($urandom_range(0, 15));
				add_item(OP_READ, ridx, 8'($urandom), $urandom, (i % 150) == 149);
			end else if (r < 93) begin
				rdat = 8'($urandom);
				if (s < 25) begin
					ridx = 4'($urandom_range(REG_TA_LO, REG_TB_HI));
					// high latch byte mostly zero so reloads stay short
					if (!ridx[0] && $urandom_range(0, 99) < 50)
						rdat = 8'($urandom_range(0, 60));
					if (ridx[0] && $urandom_range(0, 99) < 85) rdat = 8'h00;
				end else if (s < 45) begin
					ridx = REG_ICR;
					rdat[ICR_SET_BIT] = ($urandom_range(0, 99) < 75);
				end else if (s < 75) begin
					ridx = ($urandom_range(0, 1) == 0) ? REG_CRA : REG_CRB;
					if ($urandom_range(0, 99) < 80) begin
						rdat[CR_START_BIT] = 1'b1;
						rdat[CR_SRC_LSB +: 2] = 2'd0;
					end
				end else begin
					ridx = 4'($urandom_range(0, 15));
				end
				add_item(OP_WRITE, ridx, rdat, $urandom, (i % 150) == 149);
			end else begin
				add_item(OP_NONE, 4'($urandom), 8'($urandom), $urandom, (i % 150) == 149);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sample away from the rising edge so the driver's updates have settled
		while (pend_q.size() != 0 || in_valid || result_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
